// ----- rtl/core/htw_pkg.sv -----
// ----------------------------------------------------------------------------
// htw_pkg: shared types and constants of the hierarchical timer wheel
// Operation and status codes, queue item types and the sequencer states.
// ----------------------------------------------------------------------------
package htw_pkg;

	localparam int NUM_TIMERS_DEF       = 64;
	localparam int FIRST_LEVEL_BITS_DEF = 8;
	localparam int UPPER_LEVEL_BITS_DEF = 6;
	localparam int UPPER_LEVELS_DEF     = 4;

	localparam int ENT_W    = 7;
	localparam logic [ENT_W-1:0] NIL = 7'h7F;
	localparam int OQ_DEPTH = 4;

	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_DEL  = 2'd1,
		OP_TICK = 2'd2,
		OP_BAD  = 2'd3
	} op_e_t;

	typedef enum logic [2:0] {
		ST_ADDED   = 3'd0,
		ST_FULL    = 3'd1,
		ST_DELETED = 3'd2,
		ST_NOTACT  = 3'd3,
		ST_EXPIRED = 3'd4,
		ST_NOEXP   = 3'd5
	} status_e_t;

	typedef struct packed {
		op_e_t       op;
		logic [5:0]  id;
		logic [31:0] dly;
		logic        once;
	} item_t;

	typedef struct packed {
		status_e_t  st;
		logic [5:0] id;
		logic       last;
	} res_t;

	typedef enum logic [1:0] {
		MD_ADD,
		MD_CAS,
		MD_EXP
	} mode_e_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_ADD,
		S_DEL,
		S_DEL_WR,
		S_TICK,
		S_CAS_DET,
		S_CAS_HD,
		S_CAS_WALK,
		S_CAS_PL,
		S_EXP_DET,
		S_EXP_HD,
		S_EXP_RD,
		S_EXP_EMIT,
		S_EXP_OUT,
		S_EXP_NEXT,
		S_PLACE,
		S_AP_RD,
		S_AP_WR,
		S_AP_LNK,
		S_EMIT
	} ex_state_t;

endpackage

// ----- rtl/core/htw_front.sv -----
// ----------------------------------------------------------------------------
// htw_front: command intake queue
// Accepts operations, drops unknown codes and buffers two commands.
// ----------------------------------------------------------------------------
module htw_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [1:0]    operation,
	input  logic [5:0]    timer_id,
	input  logic [31:0]   delay,
	input  logic          one_shot,
	output htw_pkg::item_t itm,
	output logic          itm_vld,
	input  logic          itm_pop
);
	import htw_pkg::*;

	item_t      buf_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       acc;
	logic       keep;

	assign full    = (cnt_q == 2'd2);
	assign acc     = push && !full;
	// unknown operation codes take the transaction but leave no command
	assign keep    = acc && (op_e_t'(operation) != OP_BAD);
	assign itm     = buf_q[rd_q];
	assign itm_vld = (cnt_q != 2'd0);

	always_ff @(posedge clk) begin
		if (keep) begin
			buf_q[wr_q] <= '{op: op_e_t'(operation), id: timer_id, dly: delay,
				once: one_shot};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (keep)
				wr_q <= !wr_q;
			if (itm_pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(keep) - 2'(itm_pop);
		end
	end

endmodule

// ----- rtl/core/htw_outq.sv -----
// ----------------------------------------------------------------------------
// htw_outq: result queue
// Holds finished results until the receiver pops them.
// ----------------------------------------------------------------------------
module htw_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  htw_pkg::res_t res,
	input  logic          res_push,
	output logic          res_full,
	output logic          empty,
	input  logic          pop,
	output htw_pkg::res_t head
);
	import htw_pkg::*;

	localparam int PW = $clog2(OQ_DEPTH);

	res_t        buf_q [OQ_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0]   cnt_q;
	logic        do_pop;

	assign res_full = (cnt_q == (PW+1)'(OQ_DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_pop   = pop && !empty;
	assign head     = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (res_push)
			buf_q[wr_q] <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (res_push)
				wr_q <= wr_q + 1'b1;
			if (do_pop)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(res_push) - (PW+1)'(do_pop);
		end
	end

endmodule

// ----- rtl/core/htw_exec.sv -----
// ----------------------------------------------------------------------------
// htw_exec: timer wheel sequencer
// Runs add, delete and tick commands over the bucket and entry memories.
// ----------------------------------------------------------------------------
module htw_exec #(
	parameter int NUM_TIMERS       = htw_pkg::NUM_TIMERS_DEF,
	parameter int FIRST_LEVEL_BITS = htw_pkg::FIRST_LEVEL_BITS_DEF,
	parameter int UPPER_LEVEL_BITS = htw_pkg::UPPER_LEVEL_BITS_DEF,
	parameter int UPPER_LEVELS     = htw_pkg::UPPER_LEVELS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  htw_pkg::item_t itm,
	input  logic           itm_vld,
	output logic           itm_pop,
	output htw_pkg::res_t  res,
	output logic           res_push,
	input  logic           res_full
);
	import htw_pkg::*;

	localparam int L0 = 1 << FIRST_LEVEL_BITS;
	localparam int UP = 1 << UPPER_LEVEL_BITS;
	localparam int NB = L0 + UPPER_LEVELS * UP;
	localparam int BW = $clog2(NB);
	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int LW = (UPPER_LEVELS > 1) ? $clog2(UPPER_LEVELS) : 1;

	function automatic logic [BW-1:0] place_bkt(input logic [31:0] ex,
		input logic [31:0] base);
		logic [31:0] diff;
		logic [63:0] lim;
		logic [63:0] pos;
		logic        found;
		logic [BW-1:0] b;
		int          sh;
		diff  = ex - base;
		found = 1'b0;
		b     = '0;
		pos   = '0;
		lim   = '0;
		sh    = 0;
		if (diff < 32'(L0)) begin
			b     = BW'(ex[FIRST_LEVEL_BITS-1:0]);
			found = 1'b1;
		end
		for (int l = 0; l < UPPER_LEVELS; l++) begin
			sh  = FIRST_LEVEL_BITS + l * UPPER_LEVEL_BITS;
			lim = 64'd1 << (sh + UPPER_LEVEL_BITS);
			if (!found && (({32'd0, diff} < lim) || (l == UPPER_LEVELS - 1))) begin
				pos = {32'd0, ex};
				// beyond the top level: park in its farthest slot
				if ({32'd0, diff} >= lim)
					pos = ({32'd0, base} + lim - 64'd1) & 64'hFFFF_FFFF;
				b = BW'(L0 + l * UP) + BW'((pos >> sh) & 64'(UP - 1));
				found = 1'b1;
			end
		end
		return b;
	endfunction

	// memories
	logic [ENT_W-1:0] hd_mem [NB];
	logic [ENT_W-1:0] tl_mem [NB];
	logic [ENT_W-1:0] prv_mem [NUM_TIMERS];
	logic [ENT_W-1:0] nxt_mem [NUM_TIMERS];
	logic [31:0]      exp_mem [NUM_TIMERS];
	logic [31:0]      rel_mem [NUM_TIMERS];
	logic [BW-1:0]    ebk_mem [NUM_TIMERS];

	logic hd_we, tl_we, prv_we, nxt_we, exp_we, rel_we, ebk_we;
	logic [BW-1:0] hd_wa, tl_wa, hd_ra, tl_ra;
	logic [ENT_W-1:0] hd_wd, tl_wd, prv_wd, nxt_wd;
	logic [IW-1:0] prv_wa, nxt_wa, exp_wa, rel_wa, ebk_wa;
	logic [IW-1:0] prv_ra, nxt_ra, exp_ra, rel_ra, ebk_ra;
	logic [31:0] exp_wd, rel_wd;
	logic [BW-1:0] ebk_wd;
	logic [ENT_W-1:0] hd_rd, tl_rd, prv_rd, nxt_rd;
	logic [31:0] exp_rd, rel_rd;
	logic [BW-1:0] ebk_rd;

	// control and datapath registers
	ex_state_t state_q, state_d;
	mode_e_t   mode_q;
	logic [BW-1:0]   clr_q;
	logic [NUM_TIMERS-1:0] act_q;
	logic [NUM_TIMERS-1:0] one_q;
	logic [31:0]     tick_q;
	logic [LW-1:0]   lvl_q;
	item_t           itm_q;
	res_t            res_q;
	logic [ENT_W-1:0] cur_q, nxt_q, tmp_q;
	logic [31:0]     exp_q, rel_q;
	logic [BW-1:0]   bkt_q;

	logic          fr_hit;
	logic [IW-1:0] fr_id;
	logic          del_ok;
	logic [UPPER_LEVEL_BITS-1:0] casc_idx;
	logic [BW-1:0] casc_bkt;
	logic          casc_stop;
	logic [31:0]   nexp;
	logic          ap_done;
	ex_state_t     ap_next;
	logic [IW-1:0] cur_i;
	logic [IW-1:0] id_i;

	assign cur_i = cur_q[IW-1:0];
	assign id_i  = itm_q.id[IW-1:0];

	// lowest free entry
	always_comb begin
		fr_hit = 1'b0;
		fr_id  = '0;
		for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
			if (!act_q[i]) begin
				fr_hit = 1'b1;
				fr_id  = IW'(i);
			end
		end
	end

	assign del_ok    = ({1'b0, itm_q.id} < 7'(NUM_TIMERS)) && act_q[id_i];
	assign casc_idx  = UPPER_LEVEL_BITS'({32'd0, tick_q} >>
		(FIRST_LEVEL_BITS + int'(lvl_q) * UPPER_LEVEL_BITS));
	assign casc_bkt  = BW'(L0) + BW'(lvl_q) * BW'(UP) + BW'(casc_idx);
	assign casc_stop = (casc_idx != '0) || (lvl_q == LW'(UPPER_LEVELS - 1));
	assign nexp      = tick_q + ((rel_q == 32'd0) ? 32'd1 : rel_q);
	assign ap_done   = ((state_q == S_AP_WR) && (tl_rd == NIL)) || (state_q == S_AP_LNK);

	always_comb begin
		unique case (mode_q)
			MD_ADD:  ap_next = S_EMIT;
			MD_CAS:  ap_next = S_CAS_WALK;
			default: ap_next = S_EXP_NEXT;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:    if (clr_q == BW'(NB - 1)) state_d = S_IDLE;
			S_IDLE: begin
				if (itm_vld) begin
					unique case (itm.op)
						OP_ADD:  state_d = S_ADD;
						OP_DEL:  state_d = S_DEL;
						OP_TICK: state_d = S_TICK;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_ADD:      state_d = fr_hit ? S_PLACE : S_EMIT;
			S_DEL:      state_d = del_ok ? S_DEL_WR : S_EMIT;
			S_DEL_WR:   state_d = S_EMIT;
			S_TICK: begin
				if (tick_q[FIRST_LEVEL_BITS-1:0] == '0)
					state_d = S_CAS_DET;
				else
					state_d = S_EXP_DET;
			end
			S_CAS_DET:  state_d = S_CAS_HD;
			S_CAS_HD:   state_d = S_CAS_WALK;
			S_CAS_WALK: begin
				if (cur_q != NIL)
					state_d = S_CAS_PL;
				else if (casc_stop)
					state_d = S_EXP_DET;
				else
					state_d = S_CAS_DET;
			end
			S_CAS_PL:   state_d = S_PLACE;
			S_EXP_DET:  state_d = S_EXP_HD;
			S_EXP_HD:   state_d = (hd_rd == NIL) ? S_EMIT : S_EXP_RD;
			S_EXP_RD:   state_d = S_EXP_EMIT;
			S_EXP_EMIT: state_d = S_EXP_OUT;
			S_EXP_OUT: begin
				if (!res_full)
					state_d = one_q[cur_i] ? S_EXP_NEXT : S_PLACE;
			end
			S_EXP_NEXT: state_d = (cur_q == NIL) ? S_IDLE : S_EXP_RD;
			S_PLACE:    state_d = S_AP_RD;
			S_AP_RD:    state_d = S_AP_WR;
			S_AP_WR:    state_d = (tl_rd == NIL) ? ap_next : S_AP_LNK;
			S_AP_LNK:   state_d = ap_next;
			S_EMIT:     if (!res_full) state_d = S_IDLE;
			default:    state_d = S_CLEAR;
		endcase
	end

	// outputs and memory controls
	always_comb begin
		itm_pop  = (state_q == S_IDLE) && itm_vld;
		res_push = 1'b0;
		res      = res_q;
		hd_we = 1'b0; hd_wa = bkt_q; hd_wd = NIL; hd_ra = casc_bkt;
		tl_we = 1'b0; tl_wa = bkt_q; tl_wd = NIL; tl_ra = bkt_q;
		prv_we = 1'b0; prv_wa = cur_i; prv_wd = tl_rd; prv_ra = id_i;
		nxt_we = 1'b0; nxt_wa = cur_i; nxt_wd = NIL; nxt_ra = cur_i;
		exp_we = 1'b0; exp_wa = cur_i; exp_wd = nexp; exp_ra = cur_i;
		rel_we = 1'b0; rel_wa = fr_id; rel_wd = itm_q.dly; rel_ra = cur_i;
		ebk_we = 1'b0; ebk_wa = cur_i; ebk_wd = bkt_q; ebk_ra = id_i;
		unique case (state_q)
			S_CLEAR: begin
				hd_we = 1'b1; hd_wa = clr_q;
				tl_we = 1'b1; tl_wa = clr_q;
			end
			S_ADD: begin
				if (fr_hit) begin
					exp_we = 1'b1; exp_wa = fr_id; exp_wd = tick_q + itm_q.dly;
					rel_we = 1'b1;
				end
			end
			S_DEL: nxt_ra = id_i;
			S_DEL_WR: begin
				// splice the entry out of its bucket
				if (prv_rd == NIL) begin
					hd_we = 1'b1; hd_wa = ebk_rd; hd_wd = nxt_rd;
				end else begin
					nxt_we = 1'b1; nxt_wa = prv_rd[IW-1:0]; nxt_wd = nxt_rd;
				end
				if (nxt_rd == NIL) begin
					tl_we = 1'b1; tl_wa = ebk_rd; tl_wd = prv_rd;
				end else begin
					prv_we = 1'b1; prv_wa = nxt_rd[IW-1:0]; prv_wd = prv_rd;
				end
			end
			S_CAS_DET: begin
				hd_we = 1'b1; hd_wa = casc_bkt;
				tl_we = 1'b1; tl_wa = casc_bkt;
			end
			S_EXP_DET: begin
				hd_ra = BW'(tick_q[FIRST_LEVEL_BITS-1:0]);
				hd_we = 1'b1; hd_wa = BW'(tick_q[FIRST_LEVEL_BITS-1:0]);
				tl_we = 1'b1; tl_wa = BW'(tick_q[FIRST_LEVEL_BITS-1:0]);
			end
			S_EXP_OUT: begin
				if (!res_full) begin
					res_push = 1'b1;
					res = '{st: ST_EXPIRED, id: cur_q[5:0], last: (nxt_q == NIL)};
					exp_we = !one_q[cur_i];
				end
			end
			S_AP_WR: begin
				prv_we = 1'b1;
				nxt_we = 1'b1;
				tl_we  = 1'b1; tl_wd = cur_q;
				ebk_we = 1'b1;
				if (tl_rd == NIL) begin
					hd_we = 1'b1; hd_wd = cur_q;
				end
			end
			S_AP_LNK: begin
				nxt_we = 1'b1; nxt_wa = tmp_q[IW-1:0]; nxt_wd = cur_q;
			end
			S_EMIT: res_push = !res_full;
			default: ;
		endcase
	end

	// memory ports: one write, one registered read each
	always_ff @(posedge clk) begin
		if (hd_we) hd_mem[hd_wa] <= hd_wd;
		if (tl_we) tl_mem[tl_wa] <= tl_wd;
		if (prv_we) prv_mem[prv_wa] <= prv_wd;
		if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
		if (exp_we) exp_mem[exp_wa] <= exp_wd;
		if (rel_we) rel_mem[rel_wa] <= rel_wd;
		if (ebk_we) ebk_mem[ebk_wa] <= ebk_wd;
		hd_rd  <= hd_mem[hd_ra];
		tl_rd  <= tl_mem[tl_ra];
		prv_rd <= prv_mem[prv_ra];
		nxt_rd <= nxt_mem[nxt_ra];
		exp_rd <= exp_mem[exp_ra];
		rel_rd <= rel_mem[rel_ra];
		ebk_rd <= ebk_mem[ebk_ra];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			mode_q  <= MD_ADD;
			clr_q   <= '0;
			act_q   <= '0;
			one_q   <= '0;
			tick_q  <= '0;
			lvl_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_CLEAR: clr_q <= clr_q + 1'b1;
				S_ADD: begin
					mode_q <= MD_ADD;
					if (fr_hit) begin
						act_q[fr_id] <= 1'b1;
						one_q[fr_id] <= itm_q.once;
					end
				end
				S_DEL_WR: act_q[id_i] <= 1'b0;
				S_TICK: begin
					lvl_q  <= '0;
					mode_q <= MD_CAS;
				end
				S_CAS_WALK: if (cur_q == NIL && !casc_stop) lvl_q <= lvl_q + 1'b1;
				S_EXP_HD: begin
					mode_q <= MD_EXP;
					if (hd_rd == NIL)
						tick_q <= tick_q + 32'd1;
				end
				S_EXP_OUT: if (!res_full && one_q[cur_i]) act_q[cur_i] <= 1'b0;
				S_EXP_NEXT: if (cur_q == NIL) tick_q <= tick_q + 32'd1;
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (ap_done) begin
			if (mode_q == MD_ADD)
				res_q <= '{st: ST_ADDED, id: cur_q[5:0], last: 1'b1};
			else
				cur_q <= nxt_q;
		end
		unique case (state_q)
			S_IDLE: if (itm_vld) itm_q <= itm;
			S_ADD: begin
				if (fr_hit) begin
					cur_q <= ENT_W'(fr_id);
					exp_q <= tick_q + itm_q.dly;
				end else begin
					res_q <= '{st: ST_FULL, id: 6'd0, last: 1'b1};
				end
			end
			S_DEL:    res_q <= '{st: ST_NOTACT, id: itm_q.id, last: 1'b1};
			S_DEL_WR: res_q <= '{st: ST_DELETED, id: itm_q.id, last: 1'b1};
			S_CAS_HD: cur_q <= hd_rd;
			S_CAS_PL: begin
				nxt_q <= nxt_rd;
				exp_q <= exp_rd;
			end
			S_EXP_HD: begin
				cur_q <= hd_rd;
				res_q <= '{st: ST_NOEXP, id: 6'd0, last: 1'b1};
			end
			S_EXP_EMIT: begin
				nxt_q <= nxt_rd;
				rel_q <= rel_rd;
			end
			S_EXP_OUT: begin
				if (!res_full) begin
					if (one_q[cur_i])
						cur_q <= nxt_q;
					else
						exp_q <= nexp;
				end
			end
			S_PLACE: bkt_q <= place_bkt(exp_q, tick_q);
			S_AP_WR: tmp_q <= tl_rd;
			default: ;
		endcase
	end

endmodule

// ----- rtl/core/hierarchical_timer_wheel.sv -----
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel: timer pool on a multi-level timing wheel
// Add, delete and tick commands in; added, deleted and expired ids out.
// ----------------------------------------------------------------------------
// Commands enter through a queue port: an item is taken when push is high
// and full is low. Operation 0 adds a timer, 1 deletes one, 2 marks one
// elapsed tick; code 3 is taken and dropped. Results leave through a queue
// port: the oldest result sits on status, entry_id and last while empty is
// low and leaves when pop is high. last marks the final result of a command.
// A two-deep intake queue feeds a sequencer that owns the bucket and entry
// memories; results pass through a four-deep queue.
// Each memory step waits on a registered read, and one command is in work at
// a time. After reset the sequencer sweeps the bucket memory to empty, one
// bucket a cycle (NB = 2^FIRST_LEVEL_BITS + UPPER_LEVELS * 2^UPPER_LEVEL_BITS
// buckets, 512 by default); commands queue up meanwhile. When the receiver
// stalls, the sequencer waits on a full result queue and the intake fills up.
// ----------------------------------------------------------------------------
module hierarchical_timer_wheel #(
	parameter int NUM_TIMERS       = htw_pkg::NUM_TIMERS_DEF,
	parameter int FIRST_LEVEL_BITS = htw_pkg::FIRST_LEVEL_BITS_DEF,
	parameter int UPPER_LEVEL_BITS = htw_pkg::UPPER_LEVEL_BITS_DEF,
	parameter int UPPER_LEVELS     = htw_pkg::UPPER_LEVELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  operation,
	input  logic [5:0]  timer_id,
	input  logic [31:0] delay,
	input  logic        one_shot,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  status,
	output logic [5:0]  entry_id,
	output logic        last
);
	import htw_pkg::*;

	item_t itm;
	logic  itm_vld;
	logic  itm_pop;
	res_t  res;
	logic  res_push;
	logic  res_full;
	res_t  head;

	htw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.operation (operation),
		.timer_id  (timer_id),
		.delay     (delay),
		.one_shot  (one_shot),
		.itm       (itm),
		.itm_vld   (itm_vld),
		.itm_pop   (itm_pop)
	);

	htw_exec #(
		.NUM_TIMERS       (NUM_TIMERS),
		.FIRST_LEVEL_BITS (FIRST_LEVEL_BITS),
		.UPPER_LEVEL_BITS (UPPER_LEVEL_BITS),
		.UPPER_LEVELS     (UPPER_LEVELS)
	) u_exec (
		.clk      (clk),
		.arst_n   (arst_n),
		.itm      (itm),
		.itm_vld  (itm_vld),
		.itm_pop  (itm_pop),
		.res      (res),
		.res_push (res_push),
		.res_full (res_full)
	);

	htw_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.res_push (res_push),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.head     (head)
	);

	assign status   = head.st;
	assign entry_id = head.id;
	assign last     = head.last;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_push && res_full)) else $error("result queue overflow");

	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		itm_pop |-> itm_vld) else $error("command taken from empty intake");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ST_EXPIRED) |-> last)
		else $error("single result without last");

	a_expired_id: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_EXPIRED) |-> ({1'b0, entry_id} < 7'(NUM_TIMERS)))
		else $error("expired id out of pool");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for hierarchical_timer_wheel
// Drives add, delete and tick commands through the intake queue port,
// predicts the result stream with an in-bench wheel model and compares
// every popped transaction in order.
// ----------------------------------------------------------------------------
module tb;
	import htw_pkg::*;

	localparam int L0_SLOTS  = 256;
	localparam int UP_SLOTS  = 64;
	localparam int N_BUCKETS = L0_SLOTS + 4 * UP_SLOTS;
	localparam int CYCLE_LIMIT = 2000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [1:0]  operation = '0;
	logic [5:0]  timer_id = '0;
	logic [31:0] delay = '0;
	logic        one_shot = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [2:0]  status;
	logic [5:0]  entry_id;
	logic        last;

	hierarchical_timer_wheel i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.operation(operation),
		.timer_id (timer_id),
		.delay    (delay),
		.one_shot (one_shot),
		.empty    (empty),
		.pop      (pop),
		.status   (status),
		.entry_id (entry_id),
		.last     (last)
	);

	always #5 clk = ~clk;

	// wheel model state
	logic [31:0] now_tick;
	logic [6:0]  head_of [N_BUCKETS];
	logic [6:0]  tail_of [N_BUCKETS];
	logic [6:0]  prev_ent [64];
	logic [6:0]  next_ent [64];
	logic [31:0] expiry_of [64];
	logic [31:0] reload_of [64];
	logic [9:0]  bucket_of [64];
	bit          active [64];
	bit          once_of [64];

	item_t pending_cmds[$];
	res_t  expected_res[$];
	int    mismatches = 0;
	int    cycles = 0;
	bit    no_gaps = 1'b0;
	bit    hold_req = 1'b0;
	bit    hold_done = 1'b0;
	int    hold_cnt = 0;

	function automatic void wheel_reset();
		now_tick = '0;
		for (int b = 0; b < N_BUCKETS; b++) begin
			head_of[b] = NIL;
			tail_of[b] = NIL;
		end
		for (int e = 0; e < 64; e++) begin
			active[e] = 1'b0;
			once_of[e] = 1'b0;
		end
	endfunction

	function automatic void link_tail(int b, int e);
		logic [6:0] t;
		t = tail_of[b];
		prev_ent[e] = t;
		next_ent[e] = NIL;
		if (t == NIL) head_of[b] = 7'(e);
		else next_ent[t] = 7'(e);
		tail_of[b] = 7'(e);
		bucket_of[e] = 10'(b);
	endfunction

	function automatic void unlink(int e);
		int b;
		logic [6:0] p, n;
		b = bucket_of[e];
		p = prev_ent[e];
		n = next_ent[e];
		if (p == NIL) head_of[b] = n;
		else next_ent[p] = n;
		if (n == NIL) tail_of[b] = p;
		else prev_ent[n] = p;
	endfunction

	// choose the slot from expiry bits at the level that the distance selects
	function automatic void place_entry(int e, logic [31:0] base);
		logic [31:0] gap;
		logic [63:0] lim, pos;
		int shift;
		gap = expiry_of[e] - base;
		if (gap < L0_SLOTS) begin
			link_tail(expiry_of[e][7:0], e);
			return;
		end
		for (int lvl = 0; lvl < 4; lvl++) begin
			shift = 8 + lvl * 6;
			lim = 64'd1 << (shift + 6);
			if (64'(gap) < lim || lvl == 3) begin
				pos = 64'(expiry_of[e]);
				if (64'(gap) >= lim) pos = (64'(base) + lim - 1) & 64'hFFFF_FFFF;
				link_tail(L0_SLOTS + lvl * UP_SLOTS + int'((pos >> shift) & 63), e);
				return;
			end
		end
	endfunction

	function automatic void cascade_bucket(int b, logic [31:0] base);
		logic [6:0] e, n;
		e = head_of[b];
		head_of[b] = NIL;
		tail_of[b] = NIL;
		while (e != NIL) begin
			n = next_ent[e];
			place_entry(e, base);
			e = n;
		end
	endfunction

	function automatic void predict_results(item_t it);
		res_t out[$];
		res_t r;
		int e, idx;
		logic [31:0] t;
		logic [6:0] cur, n;
		case (it.op)
			OP_ADD: begin
				e = -1;
				for (int k = 63; k >= 0; k--)
					if (!active[k]) e = k;
				if (e < 0) begin
					r = '{st: ST_FULL, id: 6'd0, last: 1'b0};
					out.push_back(r);
				end else begin
					active[e] = 1'b1;
					once_of[e] = it.once;
					reload_of[e] = it.dly;
					expiry_of[e] = now_tick + it.dly;
					place_entry(e, now_tick);
					r = '{st: ST_ADDED, id: 6'(e), last: 1'b0};
					out.push_back(r);
				end
			end
			OP_DEL: begin
				if (active[it.id]) begin
					unlink(it.id);
					active[it.id] = 1'b0;
					r = '{st: ST_DELETED, id: it.id, last: 1'b0};
				end else begin
					r = '{st: ST_NOTACT, id: it.id, last: 1'b0};
				end
				out.push_back(r);
			end
			OP_TICK: begin
				t = now_tick;
				if (t[7:0] == 8'd0) begin
					for (int lvl = 0; lvl < 4; lvl++) begin
						idx = int'((t >> (8 + lvl * 6)) & 63);
						cascade_bucket(L0_SLOTS + lvl * UP_SLOTS + idx, t);
						if (idx != 0) break;
					end
				end
				cur = head_of[t[7:0]];
				head_of[t[7:0]] = NIL;
				tail_of[t[7:0]] = NIL;
				while (cur != NIL) begin
					n = next_ent[cur];
					r = '{st: ST_EXPIRED, id: cur[5:0], last: 1'b0};
					out.push_back(r);
					if (once_of[cur]) begin
						active[cur] = 1'b0;
					end else begin
						// zero reload re-arms for the next tick
						expiry_of[cur] = t + ((reload_of[cur] == 0) ? 32'd1 : reload_of[cur]);
						place_entry(cur, t);
					end
					cur = n;
				end
				if (out.size() == 0) begin
					r = '{st: ST_NOEXP, id: 6'd0, last: 1'b0};
					out.push_back(r);
				end
				now_tick = t + 1;
			end
			default: ;
		endcase
		if (out.size() > 0) out[out.size() - 1].last = 1'b1;
		foreach (out[i]) expected_res.push_back(out[i]);
	endfunction

	// ---- driver ----
	int send_wait = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			send_wait <= 0;
		end else begin
			if (push && !full) begin
				predict_results(item_t'({operation, timer_id, delay, one_shot}));
				if (!no_gaps && $urandom_range(0, 8) != 0) begin
					push <= 1'b0;
					send_wait <= $urandom_range(1, 8);
				end else if (pending_cmds.size() > 0) begin
					{operation, timer_id, delay, one_shot} <= pending_cmds.pop_front();
				end else begin
					push <= 1'b0;
				end
			end else if (!push) begin
				if (send_wait > 0) begin
					send_wait <= send_wait - 1;
				end else if (pending_cmds.size() > 0) begin
					{operation, timer_id, delay, one_shot} <= pending_cmds.pop_front();
					push <= 1'b1;
				end
			end
		end
	end

	// ---- long receiver stall ----
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_cnt <= hold_cnt + 1;
			if (hold_cnt == 600) hold_done <= 1'b1;
		end
	end

	// ---- monitor ----
	int recv_wait = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			recv_wait <= 0;
		end else begin
			if (pop && !empty) begin
				if (expected_res.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transaction: status=%0d id=%0d last=%0d",
							status, entry_id, last);
				end else begin
					res_t x;
					x = expected_res.pop_front();
					if (status != x.st || entry_id != x.id || last != x.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp st=%0d id=%0d last=%0d, got st=%0d id=%0d last=%0d",
								x.st, x.id, x.last, status, entry_id, last);
					end
				end
			end
			if (hold_req && !hold_done) begin
				// long stall: let the result queue and intake fill up
				pop <= 1'b0;
			end else if (pop && !empty) begin
				if ($urandom_range(0, 2) == 0) begin
					pop <= 1'b0;
					recv_wait <= $urandom_range(1, 8);
				end
			end else if (!pop) begin
				if (recv_wait > 0) recv_wait <= recv_wait - 1;
				else pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic item_t make_cmd(op_e_t op, int id, logic [31:0] dly, bit once);
		item_t it;
		it.op = op;
		it.id = 6'(id);
		it.dly = dly;
		it.once = once;
		return it;
	endfunction

	function automatic logic [31:0] rand_delay();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 20);
			1: return $urandom_range(0, 600);
			2: return $urandom_range(0, 300000);
			default: return $urandom;
		endcase
	endfunction

	function automatic item_t rand_cmd(int tick_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < tick_pct) return make_cmd(OP_TICK, $urandom_range(0, 63), $urandom, $urandom_range(0, 1));
		if (r < tick_pct + 25)
			return make_cmd(OP_ADD, $urandom_range(0, 63), rand_delay(), $urandom_range(0, 1));
		if (r < 97)
			return make_cmd(OP_DEL, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
				: $urandom_range(0, 15), $urandom, $urandom_range(0, 1));
		return make_cmd(OP_BAD, $urandom_range(0, 63), $urandom, $urandom_range(0, 1));
	endfunction

	task automatic drain_all();
		while (pending_cmds.size() > 0 || push || expected_res.size() > 0) @(posedge clk);
	endtask

	initial begin
		wheel_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: edge delays, both flavors, bad delete, ignored code
		pending_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0));
		pending_cmds.push_back(make_cmd(OP_ADD, 0, 32'd0, 1'b1));
		pending_cmds.push_back(make_cmd(OP_ADD, 0, 32'd0, 1'b0));
		pending_cmds.push_back(make_cmd(OP_ADD, 0, 32'hFFFF_FFFF, 1'b0));
		pending_cmds.push_back(make_cmd(OP_ADD, 0, 32'd255, 1'b1));
		pending_cmds.push_back(make_cmd(OP_ADD, 0, 32'd256, 1'b1));
		pending_cmds.push_back(make_cmd(OP_ADD, 63, 32'd16384, 1'b0));
		pending_cmds.push_back(make_cmd(OP_ADD, 0, 32'h0400_0000, 1'b1));
		pending_cmds.push_back(make_cmd(OP_ADD, 0, 32'd2, 1'b1));
		pending_cmds.push_back(make_cmd(OP_TICK, 63, 32'hFFFF_FFFF, 1'b1));
		pending_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0));
		pending_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0));
		pending_cmds.push_back(make_cmd(OP_DEL, 63, 0, 0));
		pending_cmds.push_back(make_cmd(OP_DEL, 2, 32'hFFFF_FFFF, 1'b1));
		pending_cmds.push_back(make_cmd(OP_DEL, 2, 0, 0));
		pending_cmds.push_back(make_cmd(OP_BAD, 5, 32'h1234_5678, 1'b1));
		pending_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0));
		drain_all();

		// fill the pool past capacity while the receiver stalls
		hold_req = 1'b1;
		no_gaps = 1'b1;
		for (int i = 0; i < 66; i++)
			pending_cmds.push_back(make_cmd(OP_ADD, 0, $urandom_range(0, 400), $urandom_range(0, 1)));
		drain_all();
		no_gaps = 1'b0;

		// random mix with gaps, then back to back
		for (int i = 0; i < 12; i++) pending_cmds.push_back(rand_cmd(45));
		drain_all();
		no_gaps = 1'b1;
		for (int i = 0; i < 10; i++) pending_cmds.push_back(rand_cmd(50));
		drain_all();

		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_res.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
